// File: rtl/wavelet_range_order_query_core_macros.svh
// assertion macros for the range order query block
`ifndef WAVELET_RANGE_ORDER_QUERY_CORE_MACROS_SVH
`define WAVELET_RANGE_ORDER_QUERY_CORE_MACROS_SVH

// implication checked on every rising clock edge outside reset
`define WROQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("check failed");

// next-cycle implication checked outside reset
`define WROQ_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("check failed");

`endif

// File: rtl/wroq_pkg.sv
package wroq_pkg;

    localparam int MaxElements = 1024;
    localparam int ValueBits   = 16;
    localparam int IdxBits     = 11;
    localparam int AddrBits    = 10;
    localparam int LevBits     = 4;
    localparam int Stride      = MaxElements + 1;
    localparam int PrefDepth   = ValueBits * Stride;
    localparam int PrefAddrBits = 15;

    localparam logic [1:0] MODE_LOAD  = 2'd0;
    localparam logic [1:0] MODE_KTH   = 2'd1;
    localparam logic [1:0] MODE_ATMOS = 2'd2;
    localparam logic [1:0] MODE_EQUAL = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_NOBLD = 2'd2;

    localparam logic CFG_VMIN = 1'b0;
    localparam logic CFG_VMAX = 1'b1;

    typedef struct packed {
        logic [1:0]         mode;
        logic [15:0]        element_value;
        logic               last_element;
        logic [IdxBits-1:0] left_index;
        logic [IdxBits-1:0] right_index;
        logic [15:0]        query_operand;
    } t_in_item;

    typedef struct packed {
        logic signed [16:0] answer_value;
        logic [IdxBits-1:0] tally;
        logic [1:0]         status;
    } t_out_item;

    function automatic logic [15:0] mid16(input logic [15:0] lo, input logic [15:0] hi);
        logic [16:0] s;
        s = {1'b0, lo} + {1'b0, hi};
        return s[16:1];
    endfunction

endpackage

// File: rtl/wroq_ram.sv
module wroq_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// File: rtl/wroq_front.sv
module wroq_front import wroq_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_stall,
    input  t_in_item i_item,
    output logic     o_q_valid,
    input  logic     i_q_pop,
    output t_in_item o_q_item
);
    // two-entry queue between front and back
    t_in_item r_ent [2];
    logic     r_rd, r_wr;
    logic [1:0] r_cnt;
    logic push;

    assign o_stall   = (r_cnt == 2'd2);
    assign push      = i_valid && !o_stall;
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_item  = r_ent[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd  <= 1'b0;
            r_wr  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_ent[r_wr] <= i_item;
                r_wr <= ~r_wr;
            end
            if (i_q_pop) r_rd <= ~r_rd;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, i_q_pop};
        end
    end
endmodule

// File: rtl/wroq_back.sv
module wroq_back import wroq_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_q_valid,
    output logic        o_q_pop,
    input  t_in_item    i_q_item,
    input  logic [15:0] i_vmin,
    input  logic [15:0] i_vmax,
    output logic        o_idle,
    output logic        o_valid,
    input  logic        i_stall,
    output t_out_item   o_item
);
    typedef enum logic [3:0] {
        S_IDLE, S_COPY, S_BLV, S_BPASS1, S_BPASS2, S_BSWAP,
        S_QSETUP, S_QRD, S_QWAIT, S_QSTEP, S_OUT
    } t_state;

    // element word of the partition banks: value and its node bounds at this level
    typedef struct packed {
        logic [15:0] val;
        logic [15:0] lo;
        logic [15:0] hi;
    } t_ent;

    t_state r_state;
    t_in_item r_it;
    logic [IdxBits-1:0] r_count;
    logic r_ready;
    logic [15:0] r_blo, r_bhi;
    // build
    logic [LevBits-1:0] r_lev;
    logic [IdxBits-1:0] r_i, r_t;
    logic r_pipe;
    logic [IdxBits-1:0] r_pc, r_w;
    logic r_bank;
    logic [IdxBits-1:0] r_gs, r_ge;
    logic [15:0] r_glo;
    logic r_first;
    // query
    logic [15:0] r_lo, r_hi, r_x;
    logic [IdxBits-1:0] r_l, r_r, r_s, r_size, r_acc;
    logic [4:0] r_d;
    logic [1:0] r_ph;
    logic [IdxBits-1:0] r_pb, r_pl, r_pr;
    logic r_ovalid;
    t_out_item r_out, r_res;

    // element banks: bank a / bank b ping-pong between levels, element store separate
    logic e_we; logic [AddrBits-1:0] e_wa, e_ra; logic [15:0] e_wd, e_rd;
    logic a_we, b_we; logic [AddrBits-1:0] a_wa, a_ra, b_wa, b_ra;
    t_ent a_wd, b_wd, a_rd, b_rd;
    logic p_we; logic [PrefAddrBits-1:0] p_wa, p_ra; logic [IdxBits-1:0] p_wd, p_rd;

    wroq_ram #(.WIDTH(16), .DEPTH(MaxElements)) u_elem (
        .i_clk, .i_we(e_we), .i_waddr(e_wa), .i_wdata(e_wd), .i_raddr(e_ra), .o_rdata(e_rd));
    wroq_ram #(.WIDTH($bits(t_ent)), .DEPTH(MaxElements)) u_bank_a (
        .i_clk, .i_we(a_we), .i_waddr(a_wa), .i_wdata(a_wd), .i_raddr(a_ra), .o_rdata(a_rd));
    wroq_ram #(.WIDTH($bits(t_ent)), .DEPTH(MaxElements)) u_bank_b (
        .i_clk, .i_we(b_we), .i_waddr(b_wa), .i_wdata(b_wd), .i_raddr(b_ra), .o_rdata(b_rd));
    wroq_ram #(.WIDTH(IdxBits), .DEPTH(PrefDepth)) u_pref (
        .i_clk, .i_we(p_we), .i_waddr(p_wa), .i_wdata(p_wd), .i_raddr(p_ra), .o_rdata(p_rd));

    logic [15:0] hi_eff, clamped, nmid;
    t_ent cur_e, nxt_e;
    logic go_left, leaf, same_grp;
    logic [4:0] k;
    logic [PrefAddrBits-1:0] lev_base, q_base;
    logic [IdxBits-1:0] q_idx, lb, rb, tot, inl, span;
    logic qleft;

    assign hi_eff  = (i_vmax < i_vmin) ? i_vmin : i_vmax;
    always_comb begin
        clamped = i_q_item.element_value;
        if (clamped < i_vmin) clamped = i_vmin;
        if (clamped > hi_eff) clamped = hi_eff;
    end

    assign cur_e = r_bank ? b_rd : a_rd;
    // one halving step of the element's node
    always_comb begin
        nmid = mid16(cur_e.lo, cur_e.hi);
        leaf = (cur_e.lo == cur_e.hi);
        go_left = !leaf && (cur_e.val <= nmid);
        nxt_e = cur_e;
        if (go_left) nxt_e.hi = nmid;
        else if (!leaf) nxt_e.lo = nmid + 16'd1;
    end
    assign same_grp = r_first || (cur_e.lo == r_glo);

    assign k = 5'd0;
    assign lev_base = PrefAddrBits'(r_lev) * PrefAddrBits'(Stride);
    assign q_base   = PrefAddrBits'(r_d[LevBits-1:0]) * PrefAddrBits'(Stride);
    always_comb begin
        case (r_ph)
            2'd0:    q_idx = r_s;
            2'd1:    q_idx = r_s + r_l - IdxBits'(1);
            2'd2:    q_idx = r_s + r_r;
            default: q_idx = r_s + r_size;
        endcase
    end
    assign lb   = r_pl - r_pb;
    assign rb   = r_pr - r_pb;
    assign tot  = p_rd - r_pb;
    assign inl  = rb - lb;
    assign span = r_r - r_l + IdxBits'(1);
    assign qleft = (r_it.mode == MODE_KTH) ? ({5'd0, inl} >= r_x) : (r_x <= mid16(r_lo, r_hi));

    // node groups are partitioned one at a time: pass1 writes left-goers, pass2 right-goers
    always_comb begin
        e_we = 1'b0; e_wa = r_count[AddrBits-1:0]; e_wd = clamped; e_ra = r_i[AddrBits-1:0];
        a_we = 1'b0; b_we = 1'b0;
        a_wa = r_w[AddrBits-1:0]; b_wa = r_w[AddrBits-1:0];
        a_wd = nxt_e; b_wd = nxt_e;
        a_ra = r_i[AddrBits-1:0]; b_ra = r_i[AddrBits-1:0];
        p_we = 1'b0;
        p_wa = lev_base + PrefAddrBits'(r_t + IdxBits'(1));
        p_wd = r_pc + (go_left ? IdxBits'(1) : IdxBits'(0));
        p_ra = q_base + PrefAddrBits'(q_idx);
        o_q_pop = 1'b0;
        if (r_state == S_IDLE && i_q_valid) begin
            o_q_pop = 1'b1;
            if (i_q_item.mode == MODE_LOAD && !(r_ready) && r_count < IdxBits'(MaxElements))
                e_we = 1'b1;
            if (i_q_item.mode == MODE_LOAD && r_ready) begin
                e_we = 1'b1; e_wa = '0;
            end
        end
        if (r_state == S_COPY && r_pipe) begin
            a_we = 1'b1; a_wd = {e_rd, r_blo, r_bhi};
        end
        if (r_state == S_BPASS1 && r_pipe && same_grp) begin
            if (go_left) begin
                if (r_bank) a_we = 1'b1; else b_we = 1'b1;
            end
            p_we = 1'b1;
        end
        if (r_state == S_BPASS2 && r_pipe && !go_left) begin
            if (r_bank) a_we = 1'b1; else b_we = 1'b1;
        end
        if (r_state == S_BLV) begin
            p_we = 1'b1; p_wa = lev_base; p_wd = '0;
        end
    end

    logic [IdxBits-1:0] newcount;
    assign newcount = (r_ready ? IdxBits'(0) : r_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_count <= '0; r_ready <= 1'b0; r_ovalid <= 1'b0;
            r_blo <= '0; r_bhi <= '0;
        end else begin
            if (r_state == S_OUT && (!r_ovalid || !i_stall)) begin
                r_ovalid <= 1'b1; r_res <= r_out;
            end else if (r_ovalid && !i_stall) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (o_q_pop) begin
                        r_it <= i_q_item;
                        r_out.answer_value <= -17'sd1;
                        r_out.tally <= '0;
                        r_out.status <= ST_OK;
                        if (i_q_item.mode == MODE_LOAD) begin
                            r_ready <= 1'b0;
                            if (newcount < IdxBits'(MaxElements)) begin
                                r_count <= newcount + IdxBits'(1);
                                if (i_q_item.last_element) begin
                                    r_blo <= i_vmin; r_bhi <= hi_eff;
                                    r_i <= '0; r_w <= '0; r_pipe <= 1'b0;
                                    r_state <= S_COPY;
                                end else r_state <= S_OUT;
                            end else begin
                                r_out.status <= ST_RANGE;
                                if (i_q_item.last_element) begin
                                    r_blo <= i_vmin; r_bhi <= hi_eff;
                                    r_i <= '0; r_w <= '0; r_pipe <= 1'b0;
                                    r_state <= S_COPY;
                                end else r_state <= S_OUT;
                            end
                        end else if (!r_ready) begin
                            r_out.status <= ST_NOBLD; r_state <= S_OUT;
                        end else if (i_q_item.left_index > i_q_item.right_index) begin
                            r_state <= S_OUT;
                        end else if (i_q_item.left_index == '0 ||
                                     i_q_item.right_index > r_count) begin
                            r_out.status <= ST_RANGE; r_state <= S_OUT;
                        end else if (i_q_item.mode == MODE_KTH && (i_q_item.query_operand == '0 ||
                                 i_q_item.query_operand > 16'(i_q_item.right_index -
                                 i_q_item.left_index + IdxBits'(1)))) begin
                            r_out.status <= ST_RANGE; r_state <= S_OUT;
                        end else begin
                            r_lo <= r_blo; r_hi <= r_bhi; r_x <= i_q_item.query_operand;
                            r_l <= i_q_item.left_index; r_r <= i_q_item.right_index;
                            r_s <= '0; r_size <= r_count; r_acc <= '0; r_d <= '0;
                            r_state <= S_QSETUP;
                        end
                    end
                end
                S_COPY: begin
                    // element store into bank a
                    r_pipe <= (r_i < r_count);
                    if (r_pipe) r_w <= r_w + IdxBits'(1);
                    if (r_i < r_count) r_i <= r_i + IdxBits'(1);
                    else if (!r_pipe) begin
                        r_lev <= '0; r_bank <= 1'b0; r_state <= S_BLV;
                    end
                end
                S_BLV: begin
                    r_i <= '0; r_w <= '0; r_pc <= '0; r_pipe <= 1'b0;
                    r_gs <= '0; r_first <= 1'b1;
                    r_state <= S_BPASS1;
                end
                S_BPASS1: begin
                    if (r_pipe && !same_grp) begin
                        r_ge <= r_t; r_i <= r_gs; r_pipe <= 1'b0;
                        r_state <= S_BPASS2;
                    end else if (!r_pipe && !(r_i < r_count)) begin
                        r_ge <= r_count; r_i <= r_gs;
                        r_state <= S_BPASS2;
                    end else begin
                        r_pipe <= (r_i < r_count);
                        if (r_i < r_count) r_i <= r_i + IdxBits'(1);
                        r_t <= r_i;
                        if (r_pipe) begin
                            if (r_first) begin
                                r_glo <= cur_e.lo; r_first <= 1'b0;
                            end
                            if (go_left) begin
                                r_w <= r_w + IdxBits'(1);
                                r_pc <= r_pc + IdxBits'(1);
                            end
                        end
                    end
                end
                S_BPASS2: begin
                    if (!r_pipe && !(r_i < r_ge)) begin
                        if (r_ge == r_count) r_state <= S_BSWAP;
                        else begin
                            r_i <= r_ge; r_gs <= r_ge; r_first <= 1'b1;
                            r_state <= S_BPASS1;
                        end
                    end else begin
                        r_pipe <= (r_i < r_ge);
                        if (r_i < r_ge) r_i <= r_i + IdxBits'(1);
                        if (r_pipe && !go_left) r_w <= r_w + IdxBits'(1);
                    end
                end
                S_BSWAP: begin
                    r_bank <= ~r_bank;
                    if (r_lev == LevBits'(ValueBits - 1)) begin
                        r_ready <= 1'b1; r_state <= S_OUT;
                    end else begin
                        r_lev <= r_lev + LevBits'(1); r_state <= S_BLV;
                    end
                end
                S_QSETUP: begin
                    if (r_it.mode == MODE_ATMOS && (r_l > r_r || r_x < r_lo)) begin
                        r_out.tally <= r_acc; r_state <= S_OUT;
                    end else if (r_it.mode == MODE_ATMOS && r_hi <= r_x) begin
                        r_out.tally <= r_acc + span; r_state <= S_OUT;
                    end else if (r_it.mode == MODE_EQUAL &&
                                 (r_l > r_r || r_x < r_lo || r_x > r_hi)) begin
                        r_state <= S_OUT;
                    end else if (r_it.mode == MODE_EQUAL && r_lo == r_hi) begin
                        r_out.tally <= span; r_state <= S_OUT;
                    end else if (r_it.mode == MODE_KTH && r_lo == r_hi) begin
                        r_out.answer_value <= {1'b0, r_lo}; r_state <= S_OUT;
                    end else if (r_d >= 5'(ValueBits)) begin
                        if (r_it.mode == MODE_KTH) r_out.answer_value <= {1'b0, r_lo};
                        else r_out.tally <= r_acc;
                        r_state <= S_OUT;
                    end else begin
                        r_ph <= 2'd0; r_state <= S_QRD;
                    end
                end
                S_QRD: r_state <= S_QWAIT;
                S_QWAIT: begin
                    case (r_ph)
                        2'd0: r_pb <= p_rd;
                        2'd1: r_pl <= p_rd;
                        2'd2: r_pr <= p_rd;
                        default: ;
                    endcase
                    if (r_ph == 2'd3) r_state <= S_QSTEP;
                    else begin
                        r_ph <= r_ph + 2'd1; r_state <= S_QRD;
                    end
                end
                S_QSTEP: begin
                    if (qleft) begin
                        r_l <= lb + IdxBits'(1); r_r <= rb; r_hi <= mid16(r_lo, r_hi);
                        r_size <= tot;
                    end else begin
                        if (r_it.mode == MODE_KTH) r_x <= r_x - {5'd0, inl};
                        if (r_it.mode == MODE_ATMOS) r_acc <= r_acc + inl;
                        r_l <= r_l - lb; r_r <= r_r - rb; r_s <= r_s + tot;
                        r_size <= r_size - tot; r_lo <= mid16(r_lo, r_hi) + 16'd1;
                    end
                    r_d <= r_d + 5'd1 + k;
                    r_state <= S_QSETUP;
                end
                S_OUT: begin
                    if (!r_ovalid || !i_stall) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_idle  = (r_state == S_IDLE);
    assign o_valid = r_ovalid;
    assign o_item  = r_res;
endmodule

// File: rtl/wavelet_range_order_query_core.sv
// wavelet tree range order query engine
// input channel: i_in_valid / o_in_stall carry one t_in_item per transaction;
// mode 0 loads an element (clamped to value_min..value_max), the element
// flagged last builds the structure over all loaded elements
// modes 1..3 answer k-th smallest, count at most x, count equal x over [l,r]
// output channel: o_out_valid / i_out_stall, exactly one result per item
// config channel: i_cfg_valid / o_cfg_ready, index 0 value_min, 1 value_max;
// ready only while no transaction is queued or being processed
// a non-final load or a query that fails its checks goes straight to the output;
// a query walks at most 16 levels, with four serial prefix-count reads a level
// build: a copy of the element store into bank a, then per level two passes
// per node group at that level, 16 levels, one bank read per element per pass
// items are handled one at a time; a two-entry queue takes items meanwhile
// reset clears the element count and the built flag; memories are not cleared
// a stalled result holds in the output register; the back end finishes the
// next item and waits until the register is free
module wavelet_range_order_query_core import wroq_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_item    i_in_item,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_item   o_out_item,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    logic [15:0] r_vmin, r_vmax;
    logic q_valid, q_pop;
    logic back_idle;
    t_in_item q_item;

    assign o_cfg_ready = !q_valid && back_idle;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vmin <= 16'd0;
            r_vmax <= 16'hffff;
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == CFG_VMIN) r_vmin <= i_cfg_data;
            else r_vmax <= i_cfg_data;
        end
    end

    wroq_front u_front (
        .i_clk, .i_rst_n, .i_valid(i_in_valid), .o_stall(o_in_stall), .i_item(i_in_item),
        .o_q_valid(q_valid), .i_q_pop(q_pop), .o_q_item(q_item));

    wroq_back u_back (
        .i_clk, .i_rst_n, .i_q_valid(q_valid), .o_q_pop(q_pop), .i_q_item(q_item),
        .i_vmin(r_vmin), .i_vmax(r_vmax), .o_idle(back_idle), .o_valid(o_out_valid),
        .i_stall(i_out_stall), .o_item(o_out_item));
endmodule

// File: rtl/wroq_checker.sv
`include "wavelet_range_order_query_core_macros.svh"
module wroq_checker import wroq_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_item o_out_item
);
    `WROQ_ASSERT_NXT(a_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_item))
    `WROQ_ASSERT_IMP(a_status, i_clk, i_rst_n, o_out_valid, o_out_item.status != 2'd3)
    `WROQ_ASSERT_IMP(a_errans, i_clk, i_rst_n, o_out_valid && o_out_item.status != ST_OK, o_out_item.answer_value == -17'sd1 && o_out_item.tally == '0)
endmodule

bind wavelet_range_order_query_core wroq_checker u_chk (
    .i_clk, .i_rst_n, .o_out_valid, .i_out_stall, .o_out_item);

// File: tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import wroq_pkg::*;

    localparam int HoldCycles = 500;
    localparam int CycleLimit = 3000000;
    localparam int ItemTarget = 1750;
    localparam int QuietFrom  = 1550;

    typedef struct packed {
        logic        idx;
        logic [15:0] data;
    } t_reg_write;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        in_valid = 1'b0;
    t_in_item    in_item = '0;
    logic        out_stall = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_index = 1'b0;
    logic [15:0] cfg_data = '0;
    logic        o_in_stall;
    logic        o_out_valid;
    t_out_item   o_out_item;
    logic        o_cfg_ready;

    t_in_item    pending_items[$];
    t_reg_write  pending_writes[$];
    t_out_item   expected_answers[$];

    // predictor state
    logic [15:0] stored_vals[MaxElements];
    int          stored_count = 0;
    logic        tree_built = 1'b0;
    logic [15:0] range_min = 16'd0;
    logic [15:0] range_max = 16'hffff;

    // generator mirror of the config and of the array being loaded
    logic [15:0] gen_min = 16'd0;
    logic [15:0] gen_max = 16'hffff;
    logic [15:0] gen_vals[$];
    int          gen_count = 0;
    logic        gen_built = 1'b0;

    int          n_pushed = 0;
    int          n_accepted = 0;
    int          gap_cnt = 0;
    int          stall_cnt = 0;
    int          hold_cnt = 0;
    logic        hold_done = 1'b0;
    int          cycles = 0;
    logic        failed = 1'b0;

    wavelet_range_order_query_core u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (o_out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_out_item answer_query(t_in_item it);
        t_out_item   res;
        logic [15:0] lo;
        logic [15:0] hi;
        logic [15:0] v;
        logic [15:0] window[$];
        int          l;
        int          r;
        int          x;
        int          cnt;
        res.answer_value = -17'sd1;
        res.tally = '0;
        res.status = ST_OK;
        l = it.left_index;
        r = it.right_index;
        x = it.query_operand;
        if (it.mode == MODE_LOAD) begin
            lo = range_min;
            hi = (range_max < range_min) ? range_min : range_max;
            if (tree_built) begin
                tree_built = 1'b0;
                stored_count = 0;
            end
            v = it.element_value;
            if (v < lo) v = lo;
            if (v > hi) v = hi;
            if (stored_count < MaxElements) begin
                stored_vals[stored_count] = v;
                stored_count++;
            end else begin
                res.status = ST_RANGE;
            end
            if (it.last_element && stored_count > 0) tree_built = 1'b1;
        end else if (!tree_built) begin
            res.status = ST_NOBLD;
        end else if (l > r) begin
            res.status = ST_OK;
        end else if (l == 0 || r > stored_count) begin
            res.status = ST_RANGE;
        end else if (it.mode == MODE_KTH) begin
            if (x == 0 || x > r - l + 1) begin
                res.status = ST_RANGE;
            end else begin
                for (int i = l - 1; i < r; i++) window.insert(window.size(), stored_vals[i]);
                window.sort();
                res.answer_value = {1'b0, window[x-1]};
            end
        end else begin
            cnt = 0;
            for (int i = l - 1; i < r; i++) begin
                if (it.mode == MODE_ATMOS ? (stored_vals[i] <= x) : (stored_vals[i] == x))
                    cnt++;
            end
            res.tally = cnt[IdxBits-1:0];
        end
        return res;
    endfunction

    function automatic t_in_item mk(int m, int v, int last, int l, int r, int x);
        t_in_item it;
        it.mode = m[1:0];
        it.element_value = v[15:0];
        it.last_element = last[0];
        it.left_index = l[IdxBits-1:0];
        it.right_index = r[IdxBits-1:0];
        it.query_operand = x[15:0];
        return it;
    endfunction

    task automatic push(t_in_item it);
        logic [15:0] lo;
        logic [15:0] hi;
        logic [15:0] v;
        if (it.mode == MODE_LOAD) begin
            if (gen_built) begin
                gen_built = 1'b0;
                gen_vals.delete();
            end
            lo = gen_min;
            hi = (gen_max < gen_min) ? gen_min : gen_max;
            v = it.element_value;
            if (v < lo) v = lo;
            if (v > hi) v = hi;
            if (gen_vals.size() < MaxElements) gen_vals.insert(gen_vals.size(), v);
            if (it.last_element && gen_vals.size() > 0) gen_built = 1'b1;
        end
        gen_count = gen_vals.size();
        pending_items.insert(pending_items.size(), it);
        n_pushed++;
    endtask

    task automatic set_range(int lo, int hi);
        t_reg_write w;
        w.idx = CFG_VMIN;
        w.data = lo[15:0];
        pending_writes.insert(pending_writes.size(), w);
        w.idx = CFG_VMAX;
        w.data = hi[15:0];
        pending_writes.insert(pending_writes.size(), w);
        gen_min = lo[15:0];
        gen_max = hi[15:0];
        while (pending_writes.size() > 0 || cfg_valid) @(posedge i_clk);
    endtask

    task automatic load_array(int n);
        for (int i = 0; i < n; i++) begin
            // occasional query in the middle of a load sequence
            if ($urandom_range(0, 29) == 0)
                push(mk($urandom_range(1, 3), $urandom, 0, 1, 1, 1));
            push(mk(MODE_LOAD, $urandom, i == n - 1, $urandom, $urandom, $urandom));
        end
    endtask

    task automatic random_queries(int q);
        int l;
        int r;
        int x;
        int m;
        for (int i = 0; i < q; i++) begin
            m = $urandom_range(1, 3);
            if ($urandom_range(0, 9) == 0) begin
                push(mk(m, $urandom, $urandom, $urandom, $urandom, $urandom));
            end else begin
                l = $urandom_range(1, gen_count);
                r = $urandom_range(l, gen_count);
                if ($urandom_range(0, 15) == 0) l = $urandom_range(0, gen_count + 2);
                if ($urandom_range(0, 15) == 0) r = $urandom_range(0, gen_count + 2);
                if (m == MODE_KTH) begin
                    x = $urandom_range(1, (r >= l) ? r - l + 1 : 1);
                    if ($urandom_range(0, 11) == 0) x = $urandom_range(0, r - l + 3);
                end else if ($urandom_range(0, 1) && gen_count > 0) begin
                    x = gen_vals[$urandom_range(0, gen_count - 1)];
                    if ($urandom_range(0, 3) == 0) x = x + $urandom_range(0, 2) - 1;
                end else begin
                    x = $urandom;
                end
                push(mk(m, $urandom, $urandom, l, r, x));
            end
        end
    endtask

    task automatic drain();
        while (pending_items.size() > 0 || in_valid || expected_answers.size() > 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // queries before any build, then a five-element build and queries on it
        push(mk(MODE_KTH, 0, 0, 1, 1, 1));
        push(mk(MODE_ATMOS, 0, 0, 1, 1, 0));
        push(mk(MODE_EQUAL, 0, 0, 1, 1, 0));
        push(mk(MODE_LOAD, 16'd0, 0, 0, 0, 0));
        push(mk(MODE_LOAD, 16'hffff, 0, 0, 0, 0));
        push(mk(MODE_LOAD, 16'h5555, 0, 0, 0, 0));
        push(mk(MODE_LOAD, 16'haaaa, 0, 0, 0, 0));
        push(mk(MODE_LOAD, 16'd1234, 1, 0, 0, 0));
        push(mk(MODE_KTH, 0, 0, 1, 5, 1));
        push(mk(MODE_KTH, 0, 0, 1, 5, 5));
        push(mk(MODE_KTH, 0, 0, 2, 4, 0));
        push(mk(MODE_KTH, 0, 0, 2, 4, 4));
        push(mk(MODE_KTH, 0, 0, 0, 3, 1));
        push(mk(MODE_ATMOS, 0, 0, 1, 6, 0));
        push(mk(MODE_ATMOS, 0, 0, 3, 2, 0));
        push(mk(MODE_ATMOS, 0, 0, 2047, 2047, 0));
        push(mk(MODE_ATMOS, 0, 0, 1, 5, 0));
        push(mk(MODE_ATMOS, 0, 0, 1, 5, 16'hffff));
        push(mk(MODE_ATMOS, 0, 0, 1, 5, 16'h5555));
        push(mk(MODE_EQUAL, 0, 0, 1, 5, 16'haaaa));
        push(mk(MODE_EQUAL, 0, 0, 1, 5, 16'hffff));
        push(mk(MODE_EQUAL, 0, 0, 2, 5, 0));
        push(mk(MODE_KTH, 0, 0, 5, 5, 1));
        drain();

        // extreme and inverted ranges
        set_range(16'd100, 16'd200);
        load_array(12);
        random_queries(20);
        drain();
        set_range(16'd300, 16'd50);
        load_array(6);
        random_queries(10);
        drain();
        set_range(16'hffff, 16'hffff);
        load_array(5);
        random_queries(10);
        drain();
        set_range(16'd0, 16'd0);
        load_array(5);
        random_queries(10);
        drain();

        // full array with overflowing loads
        set_range(16'd0, 16'hffff);
        load_array(MaxElements + 6);
        random_queries(40);
        drain();

        while (n_pushed < ItemTarget) begin
            if ($urandom_range(0, 2) == 0) set_range($urandom, $urandom);
            else if ($urandom_range(0, 2) == 0) set_range($urandom_range(0, 300), 16'hffff);
            load_array($urandom_range(1, 40));
            random_queries($urandom_range(20, 50));
            drain();
        end

        repeat (200) @(posedge i_clk);
        if (!failed) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !o_in_stall) begin
                expected_answers.insert(expected_answers.size(), answer_query(in_item));
                n_accepted <= n_accepted + 1;
            end
            if (!in_valid || !o_in_stall) begin
                if (gap_cnt > 0) begin
                    gap_cnt <= gap_cnt - 1;
                    in_valid <= 1'b0;
                end else if (pending_items.size() > 0) begin
                    in_item <= pending_items.pop_front();
                    in_valid <= 1'b1;
                    if (n_accepted < QuietFrom && $urandom_range(0, 11) == 0)
                        gap_cnt <= $urandom_range(1, 16);
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // config writer
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg_valid <= 1'b0;
        end else begin
            if (cfg_valid && o_cfg_ready) begin
                if (cfg_index == CFG_VMIN) range_min = cfg_data;
                else range_max = cfg_data;
            end
            if (!cfg_valid || o_cfg_ready) begin
                if (pending_writes.size() > 0) begin
                    {cfg_index, cfg_data} <= pending_writes.pop_front();
                    cfg_valid <= 1'b1;
                end else begin
                    cfg_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_out_item exp_item;
        if (!i_rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !out_stall) begin
                if (expected_answers.size() == 0) begin
                    $error("unexpected transaction: answer_value %0d tally %0d status %0d",
                           o_out_item.answer_value, o_out_item.tally, o_out_item.status);
                    failed = 1'b1;
                end else begin
                    exp_item = expected_answers.pop_front();
                    if (o_out_item.answer_value !== exp_item.answer_value) begin
                        $error("answer_value: expected %0d, got %0d",
                               exp_item.answer_value, o_out_item.answer_value);
                        failed = 1'b1;
                    end
                    if (o_out_item.tally !== exp_item.tally) begin
                        $error("tally: expected %0d, got %0d", exp_item.tally, o_out_item.tally);
                        failed = 1'b1;
                    end
                    if (o_out_item.status !== exp_item.status) begin
                        $error("status: expected %0d, got %0d",
                               exp_item.status, o_out_item.status);
                        failed = 1'b1;
                    end
                end
            end
            if (hold_cnt > 0) begin
                hold_cnt <= hold_cnt - 1;
                out_stall <= 1'b1;
            end else if (!hold_done && n_accepted >= 60) begin
                hold_done <= 1'b1;
                hold_cnt <= HoldCycles;
                out_stall <= 1'b1;
            end else if (stall_cnt > 0) begin
                stall_cnt <= stall_cnt - 1;
                out_stall <= 1'b1;
            end else if (n_accepted < QuietFrom && $urandom_range(0, 15) == 0) begin
                stall_cnt <= $urandom_range(0, 15);
                out_stall <= 1'b1;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

endmodule
